### rtl/wsfs_pkg.sv
// Shared types and constants for the weak/strong fault supervisor.
// Depends on nothing; every other file imports it.
package wsfs_pkg;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int MASK_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int FAILS_W    = 8;
  localparam int AGE_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [FAILS_W-1:0] FAIL_LIMIT_RST  = 8'd3;
  localparam logic [AGE_W-1:0]   QUEUE_HOLD_RST  = 16'd1000;
  localparam logic [AGE_W-1:0]   RESET_DELAY_RST = 16'd2000;

  // Elapsed-time counters stop here instead of wrapping
  localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

  // Positions of the weak-fault bits owned by the supervisor
  localparam int WEAK_FRONT = 0;
  localparam int WEAK_REAR  = 1;
  localparam int WEAK_QUEUE = 2;

  // Event commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_SAMPLE = 3'd1,
    CMD_DROP   = 3'd2,
    CMD_WEAK   = 3'd3,
    CMD_STRONG = 3'd4
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAIL_LIMIT  = 2'd0,
    REG_QUEUE_HOLD  = 2'd1,
    REG_RESET_DELAY = 2'd2
  } reg_idx_t;

  // One event request
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               front_healthy;
    logic               rear_ok;
    logic [COUNT_W-1:0] drop_total;
    logic [MASK_W-1:0]  fault_mask;
    logic               fault_active;
  } evt_t;

  // One result request
  typedef struct packed {
    logic [MASK_W-1:0] weak_faults;
    logic              strong_pending;
    logic [MASK_W-1:0] strong_faults;
    logic              alert_active;
    logic              reset_now;
  } res_t;

  // Current configuration
  typedef struct packed {
    logic [FAILS_W-1:0] fail_limit;
    logic [AGE_W-1:0]   queue_hold;
    logic [AGE_W-1:0]   reset_delay;
  } cfg_t;

endpackage

### rtl/wsfs_if.sv
// Valid/ready channel interfaces for events, results and configuration writes.
// Depends on wsfs_pkg for field widths.
interface wsfs_evt_if;
  import wsfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic               front_healthy;
  logic               rear_ok;
  logic [COUNT_W-1:0] drop_total;
  logic [MASK_W-1:0]  fault_mask;
  logic               fault_active;

  modport source (output valid, cmd, front_healthy, rear_ok, drop_total, fault_mask,
                  fault_active, input ready);
  modport sink (input valid, cmd, front_healthy, rear_ok, drop_total, fault_mask,
                fault_active, output ready);
endinterface

interface wsfs_res_if;
  import wsfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] weak_faults;
  logic              strong_pending;
  logic [MASK_W-1:0] strong_faults;
  logic              alert_active;
  logic              reset_now;

  modport source (output valid, weak_faults, strong_pending, strong_faults, alert_active,
                  reset_now, input ready);
  modport sink (input valid, weak_faults, strong_pending, strong_faults, alert_active,
                reset_now, output ready);
endinterface

interface wsfs_cfg_if;
  import wsfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/wsfs_cfg.sv
// Configuration registers: fail limit, queue hold time and reset delay.
// Depends on wsfs_pkg and the wsfs_cfg_if interface.
module wsfs_cfg (
  input  logic           clk,
  input  logic           rst,
  wsfs_cfg_if.sink       cfg,
  output wsfs_pkg::cfg_t regs
);
  import wsfs_pkg::*;

  // Writes are always taken; ready is tied high.
  assign cfg.ready = 1'b1;

  // Register file; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fail_limit  <= FAIL_LIMIT_RST;
      regs.queue_hold  <= QUEUE_HOLD_RST;
      regs.reset_delay <= RESET_DELAY_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FAIL_LIMIT:  regs.fail_limit  <= cfg.data[FAILS_W-1:0];
        REG_QUEUE_HOLD:  regs.queue_hold  <= cfg.data[AGE_W-1:0];
        REG_RESET_DELAY: regs.reset_delay <= cfg.data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/wsfs_core.sv
// Supervisor state and its update for one event.
// Depends on wsfs_pkg; the result is the state after the update.
module wsfs_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  wsfs_pkg::evt_t evt,
  input  wsfs_pkg::cfg_t cfg,
  output wsfs_pkg::res_t res
);
  import wsfs_pkg::*;

  logic [FAILS_W-1:0] front_failures, front_failures_next;
  logic [FAILS_W-1:0] rear_failures, rear_failures_next;
  logic [MASK_W-1:0]  weak_bits, weak_bits_next;
  logic [COUNT_W-1:0] last_drop_count, last_drop_count_next;
  logic [AGE_W-1:0]   queue_age, queue_age_next;
  logic               strong_latched, strong_latched_next;
  logic [MASK_W-1:0]  strong_bits, strong_bits_next;
  logic [AGE_W-1:0]   strong_age, strong_age_next;

  // Next-state logic for the event in the input register.
  always_comb begin
    front_failures_next  = front_failures;
    rear_failures_next   = rear_failures;
    weak_bits_next       = weak_bits;
    last_drop_count_next = last_drop_count;
    queue_age_next       = queue_age;
    strong_latched_next  = strong_latched;
    strong_bits_next     = strong_bits;
    strong_age_next      = strong_age;

    unique case (evt.cmd)
      CMD_TICK: begin
        if (queue_age != AGE_MAX) queue_age_next = queue_age + 16'd1;
        if (strong_latched && strong_age != AGE_MAX) strong_age_next = strong_age + 16'd1;
      end
      CMD_SAMPLE: begin
        // Front sensor: an OK sample clears, a failure counts up to the limit.
        if (evt.front_healthy) begin
          front_failures_next        = '0;
          weak_bits_next[WEAK_FRONT] = 1'b0;
        end else if (front_failures < cfg.fail_limit) begin
          front_failures_next = front_failures + 8'd1;
          if (front_failures_next >= cfg.fail_limit) weak_bits_next[WEAK_FRONT] = 1'b1;
        end
        // Rear sensor works the same way on its own counter.
        if (evt.rear_ok) begin
          rear_failures_next        = '0;
          weak_bits_next[WEAK_REAR] = 1'b0;
        end else if (rear_failures < cfg.fail_limit) begin
          rear_failures_next = rear_failures + 8'd1;
          if (rear_failures_next >= cfg.fail_limit) weak_bits_next[WEAK_REAR] = 1'b1;
        end
      end
      CMD_DROP: begin
        // A new count raises the queue bit; a steady count clears it after the hold time.
        if (evt.drop_total != last_drop_count) begin
          last_drop_count_next       = evt.drop_total;
          queue_age_next             = '0;
          weak_bits_next[WEAK_QUEUE] = 1'b1;
        end else if (weak_bits[WEAK_QUEUE] && queue_age >= cfg.queue_hold) begin
          weak_bits_next[WEAK_QUEUE] = 1'b0;
        end
      end
      CMD_WEAK: begin
        if (evt.fault_active) weak_bits_next = weak_bits | evt.fault_mask;
        else                  weak_bits_next = weak_bits & ~evt.fault_mask;
      end
      CMD_STRONG: begin
        // Only the first request latches; the latch holds until reset.
        if (!strong_latched) begin
          strong_latched_next = 1'b1;
          strong_bits_next    = evt.fault_mask;
          strong_age_next     = '0;
        end
      end
      default: ;
    endcase
  end

  // Result reflects the state after this event.
  always_comb begin
    res.weak_faults    = weak_bits_next;
    res.strong_pending = strong_latched_next;
    res.strong_faults  = strong_bits_next;
    res.alert_active   = strong_latched_next || (weak_bits_next != '0);
    res.reset_now      = strong_latched_next && (strong_age_next >= cfg.reset_delay);
  end

  // State registers advance once per event.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_failures  <= '0;
      rear_failures   <= '0;
      weak_bits       <= '0;
      last_drop_count <= '0;
      queue_age       <= '0;
      strong_latched  <= 1'b0;
      strong_bits     <= '0;
      strong_age      <= '0;
    end else if (fire) begin
      front_failures  <= front_failures_next;
      rear_failures   <= rear_failures_next;
      weak_bits       <= weak_bits_next;
      last_drop_count <= last_drop_count_next;
      queue_age       <= queue_age_next;
      strong_latched  <= strong_latched_next;
      strong_bits     <= strong_bits_next;
      strong_age      <= strong_age_next;
    end
  end

endmodule

### rtl/weak_strong_fault_supervisor_unit.sv
// Top level of the weak/strong fault supervisor: input register, core, result register.
// Depends on wsfs_pkg, the channel interfaces, wsfs_cfg and wsfs_core.
//
//   Channel | Direction | Payload
//   evt     | in        | cmd, front_healthy, rear_ok, drop_total, fault_mask, fault_active
//   res     | out       | weak_faults, strong_pending, strong_faults, alert_active, reset_now
//   cfg     | in        | index, data (write only, always ready)
//
// One event is accepted per cycle while the result channel is not stalled; its result
// is presented from the result register after the event passes the input register.
// Between the two registers the update is one pass through the core's compares and
// counters. A stalled result holds the result register and a full input register;
// evt.ready stays high while the input register can drain. Synchronous reset clears
// the core state, the configuration registers and both valid flags.
module weak_strong_fault_supervisor_unit (
  input  logic      clk,
  input  logic      rst,
  wsfs_evt_if.sink  evt,
  wsfs_res_if.source res,
  wsfs_cfg_if.sink  cfg
);
  import wsfs_pkg::*;

  logic   stage_valid;
  evt_t   stage_evt;
  logic   res_valid;
  res_t   res_data;
  res_t   res_calc;
  cfg_t   cfg_regs;
  logic   advance;
  logic   fire;

  // Pipeline moves when the result register is empty or being taken.
  assign advance   = !res_valid || res.ready;
  assign fire      = advance && stage_valid;
  assign evt.ready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (evt.ready) begin
      stage_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      stage_evt.cmd           <= evt.cmd;
      stage_evt.front_healthy <= evt.front_healthy;
      stage_evt.rear_ok       <= evt.rear_ok;
      stage_evt.drop_total    <= evt.drop_total;
      stage_evt.fault_mask    <= evt.fault_mask;
      stage_evt.fault_active  <= evt.fault_active;
    end
  end

  wsfs_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  wsfs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .evt  (stage_evt),
    .cfg  (cfg_regs),
    .res  (res_calc)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= res_calc;
    end
  end

  assign res.valid          = res_valid;
  assign res.weak_faults    = res_data.weak_faults;
  assign res.strong_pending = res_data.strong_pending;
  assign res.strong_faults  = res_data.strong_faults;
  assign res.alert_active   = res_data.alert_active;
  assign res.reset_now      = res_data.reset_now;

endmodule

### rtl/wsfs_checker.sv
// Port-level checks on the fault supervisor's result channel, and their bind.
// Depends on wsfs_pkg and the top level weak_strong_fault_supervisor_unit.
module wsfs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [wsfs_pkg::MASK_W-1:0] weak_faults,
  input logic                      strong_pending,
  input logic [wsfs_pkg::MASK_W-1:0] strong_faults,
  input logic                      alert_active,
  input logic                      reset_now
);
  import wsfs_pkg::*;

  // The alert is exactly the summary of strong and weak state.
  a_alert_summary: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (alert_active == (strong_pending || (weak_faults != '0))))
    else $error("alert_active does not match fault state");

  // A reset demand only exists behind a latched strong fault.
  a_reset_needs_strong: assert property (@(posedge clk) disable iff (rst)
    (res_valid && reset_now) |-> strong_pending)
    else $error("reset_now without strong_pending");

  // Once latched, the strong fault and its mask persist in every later result.
  a_strong_sticky: assert property (@(posedge clk) disable iff (rst)
    (res_valid && strong_pending) |=>
      (!res_valid || (strong_pending && strong_faults == $past(strong_faults))))
    else $error("strong fault latch changed before reset");

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // A stalled result stays valid and its weak-fault mask holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(weak_faults)))
    else $error("stalled result changed");

endmodule

bind weak_strong_fault_supervisor_unit wsfs_checker u_wsfs_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .weak_faults    (res.weak_faults),
  .strong_pending (res.strong_pending),
  .strong_faults  (res.strong_faults),
  .alert_active   (res.alert_active),
  .reset_now      (res.reset_now)
);
